>>> rtl/core/bdda_pkg.sv
`timescale 1ns / 1ps

package bdda_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 15;
    localparam int WDAY_W  = 3;
    localparam int MASK_W  = 7;

    localparam logic [MASK_W-1:0]  MASK_RESET = 7'd96;
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR  = 4'd3;
    localparam logic [WDAY_W-1:0]  WDAY_SAT   = 3'd6;

    // floor(y / 100) == (y * 5243) >> 19 for every 14-bit y
    localparam logic [12:0] RECIP_100  = 13'd5243;
    localparam int          SHIFT_100  = 19;
    // floor(s / 7) == (s * 149797) >> 20 for every 15-bit s
    localparam logic [17:0] RECIP_7    = 18'd149797;
    localparam int          SHIFT_7    = 20;

    typedef logic [3:0] t_step;

    localparam t_step S_IDLE   = 4'd0;
    localparam t_step S_DIV100 = 4'd1;
    localparam t_step S_REM100 = 4'd2;
    localparam t_step S_CHECK  = 4'd3;
    localparam t_step S_SUM    = 4'd4;
    localparam t_step S_QUO    = 4'd5;
    localparam t_step S_WDAY   = 4'd6;
    localparam t_step S_WALK   = 4'd7;
    localparam t_step S_SKIP   = 4'd8;
    localparam t_step S_EMIT   = 4'd9;
    localparam t_step S_BAD    = 4'd10;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV100,
        OP_REM100,
        OP_SUM,
        OP_QUO,
        OP_WDAY,
        OP_WALK,
        OP_SKIP,
        OP_EMIT,
        OP_BAD
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IN_VALID,
        C_BAD_DATE,
        C_WALK_DONE,
        C_SKIP_DONE,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  hold;
        t_step tgt;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic bad_date;
        logic walk_done;
        logic skip_done;
        logic out_free;
    } t_sts;

    // Control store: fall through, jump on condition, or hold on the step.
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            S_IDLE:   w = '{OP_LOAD,   C_IN_VALID,  1'b1, S_DIV100};
            S_DIV100: w = '{OP_DIV100, C_NEVER,     1'b0, S_IDLE};
            S_REM100: w = '{OP_REM100, C_NEVER,     1'b0, S_IDLE};
            S_CHECK:  w = '{OP_NOP,    C_BAD_DATE,  1'b0, S_BAD};
            S_SUM:    w = '{OP_SUM,    C_NEVER,     1'b0, S_IDLE};
            S_QUO:    w = '{OP_QUO,    C_NEVER,     1'b0, S_IDLE};
            S_WDAY:   w = '{OP_WDAY,   C_NEVER,     1'b0, S_IDLE};
            S_WALK:   w = '{OP_WALK,   C_WALK_DONE, 1'b1, S_SKIP};
            S_SKIP:   w = '{OP_SKIP,   C_SKIP_DONE, 1'b1, S_EMIT};
            S_EMIT:   w = '{OP_EMIT,   C_OUT_FREE,  1'b1, S_IDLE};
            S_BAD:    w = '{OP_BAD,    C_ALWAYS,    1'b0, S_EMIT};
            default:  w = '{OP_NOP,    C_ALWAYS,    1'b0, S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
            4'd2:    n = leap ? 5'd29 : 5'd28;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    // floor(31 * mm / 12) with March as month one of the shifted year
    function automatic logic [DAY_W-1:0] month_term(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] t;
        case (m)
            4'd3:    t = 5'd2;
            4'd4:    t = 5'd5;
            4'd5:    t = 5'd7;
            4'd6:    t = 5'd10;
            4'd7:    t = 5'd12;
            4'd8:    t = 5'd15;
            4'd9:    t = 5'd18;
            4'd10:   t = 5'd20;
            4'd11:   t = 5'd23;
            4'd12:   t = 5'd25;
            4'd1:    t = 5'd28;
            4'd2:    t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/core/bdda_req_if.sv
`timescale 1ns / 1ps

interface bdda_req_if import bdda_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [COUNT_W-1:0] days_count;

    modport source (output valid, start_day, start_month, start_year, days_count,
                    input ready);
    modport sink   (input valid, start_day, start_month, start_year, days_count,
                    output ready);
endinterface

>>> rtl/core/bdda_rsp_if.sv
`timescale 1ns / 1ps

interface bdda_rsp_if import bdda_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   ret_day;
    logic [MONTH_W-1:0] ret_month;
    logic [YEAR_W-1:0]  ret_year;
    logic [WDAY_W-1:0]  ret_weekday;
    logic               bad_date;
    logic               overflow;

    modport source (output valid, ret_day, ret_month, ret_year, ret_weekday,
                           bad_date, overflow,
                    input ready);
    modport sink   (input valid, ret_day, ret_month, ret_year, ret_weekday,
                          bad_date, overflow,
                    output ready);
endinterface

>>> rtl/core/bdda_cfg_if.sv
`timescale 1ns / 1ps

interface bdda_cfg_if import bdda_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] weekend_mask;

    modport source (output valid, weekend_mask, input ready);
    modport sink   (input valid, weekend_mask, output ready);
endinterface

>>> rtl/core/bdda_seq.sv
`timescale 1ns / 1ps

module bdda_seq import bdda_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_sts   i_sts,
    output t_uword o_uword
);

    t_step  r_step;
    t_step  n_step;
    t_uword w_uword;
    logic   w_take;

    assign w_uword = ucode(r_step);
    assign o_uword = w_uword;

    always_comb begin
        unique case (w_uword.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_IN_VALID:  w_take = i_sts.in_valid;
            C_BAD_DATE:  w_take = i_sts.bad_date;
            C_WALK_DONE: w_take = i_sts.walk_done;
            C_SKIP_DONE: w_take = i_sts.skip_done;
            C_OUT_FREE:  w_take = i_sts.out_free;
            default:     w_take = 1'b1;
        endcase
        if (w_take) begin
            n_step = w_uword.tgt;
        end else if (w_uword.hold) begin
            n_step = r_step;
        end else begin
            n_step = r_step + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

>>> rtl/core/business_day_date_adder.sv
`timescale 1ns / 1ps

// Business-day date adder. A request carries a Gregorian start date and a
// count of working days; the block walks the calendar one day per clock,
// spending one count on each working day it steps over and passing days
// marked in weekend_mask (bit n = weekday n, Sunday = 0; reset marks Friday
// and Saturday) for free, then keeps stepping past any weekend days that
// follow. The response carries the return date, its weekday, a bad_date flag
// (start date echoed, weekday 0) and an overflow flag (walk stopped at
// 31/12/9999). A small microcode sequencer drives one datapath: after
// acceptance a valid request steps through DIV100, REM100, CHECK, SUM,
// QUO, WDAY, the walk, the skip past trailing weekend days and EMIT, which
// presents the response; an invalid date goes from CHECK to BAD and EMIT.
// The day-by-day walk sets the latency. One request is in flight at a
// time; the next is accepted once the response has been placed in the
// output register, even while that register still waits on ready. Write
// weekend_mask only while idle.

module business_day_date_adder import bdda_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bdda_cfg_if.sink   i_cfg,
    bdda_req_if.sink   i_req,
    bdda_rsp_if.source o_rsp
);

    // ---------------------------------------------------------------------
    // Configuration
    // ---------------------------------------------------------------------
    logic [MASK_W-1:0] r_mask;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= MASK_RESET;
        end else if (i_cfg.valid) begin
            r_mask <= i_cfg.weekend_mask;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    t_uword w_uw;
    t_sts   w_sts;

    bdda_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_uword (w_uw)
    );

    // ---------------------------------------------------------------------
    // Working registers
    // ---------------------------------------------------------------------
    logic [DAY_W-1:0]   r_d,    n_d;
    logic [MONTH_W-1:0] r_m,    n_m;
    logic [YEAR_W-1:0]  r_y,    n_y;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [7:0]         r_q100, n_q100;   // year / 100
    logic [6:0]         r_c100, n_c100;   // year % 100
    logic [COUNT_W-1:0] r_sum,  n_sum;
    logic [12:0]        r_q7,   n_q7;
    logic [WDAY_W-1:0]  r_wd,   n_wd;
    logic               r_bad,  n_bad;
    logic               r_ovf,  n_ovf;

    // Output register
    logic               r_o_valid;
    logic [DAY_W-1:0]   r_o_d;
    logic [MONTH_W-1:0] r_o_m;
    logic [YEAR_W-1:0]  r_o_y;
    logic [WDAY_W-1:0]  r_o_wd;
    logic               r_o_bad;
    logic               r_o_ovf;

    // ---------------------------------------------------------------------
    // Calendar helpers
    // ---------------------------------------------------------------------
    logic               w_leap;
    logic [DAY_W-1:0]   w_dim;
    logic               w_month_end;
    logic               w_at_limit;
    logic               w_off;
    logic [7:0]         w_mask8;
    logic               w_early;      // January or February: shifted year
    logic [YEAR_W-1:0]  w_yy;
    logic [7:0]         w_qyy;
    logic               w_accept;
    logic               w_out_free;
    logic [26:0]        w_prod100;
    logic [32:0]        w_prod7;

    // Adjusted calendar after one step
    logic [DAY_W-1:0]   w_adv_d;
    logic [MONTH_W-1:0] w_adv_m;
    logic [YEAR_W-1:0]  w_adv_y;
    logic [7:0]         w_adv_q100;
    logic [6:0]         w_adv_c100;
    logic [WDAY_W-1:0]  w_adv_wd;

    assign w_leap      = (r_y[1:0] == 2'd0) && ((r_c100 != 7'd0) || (r_q100[1:0] == 2'd0));
    assign w_dim       = days_in(r_m, w_leap);
    assign w_month_end = (r_d == w_dim);
    assign w_at_limit  = w_month_end && (r_m == MONTH_DEC) && (r_y >= YEAR_MAX);
    assign w_mask8     = {1'b0, r_mask};
    assign w_off       = w_mask8[r_wd];

    assign w_early = (r_m < MONTH_MAR);
    assign w_yy    = r_y - YEAR_W'(w_early);
    assign w_qyy   = r_q100 - 8'((w_early && (r_c100 == 7'd0)) ? 1 : 0);

    assign w_prod100 = 27'(r_y) * 27'(RECIP_100);
    assign w_prod7   = 33'(r_sum) * 33'(RECIP_7);

    always_comb begin
        w_adv_d    = r_d + 5'd1;
        w_adv_m    = r_m;
        w_adv_y    = r_y;
        w_adv_q100 = r_q100;
        w_adv_c100 = r_c100;
        if (w_month_end) begin
            w_adv_d = 5'd1;
            if (r_m == MONTH_DEC) begin
                w_adv_m = 4'd1;
                w_adv_y = r_y + 14'd1;
                if (r_c100 == 7'd99) begin
                    w_adv_c100 = 7'd0;
                    w_adv_q100 = r_q100 + 8'd1;
                end else begin
                    w_adv_c100 = r_c100 + 7'd1;
                end
            end else begin
                w_adv_m = r_m + 4'd1;
            end
        end
        w_adv_wd = (r_wd == WDAY_SAT) ? 3'd0 : r_wd + 3'd1;
    end

    // ---------------------------------------------------------------------
    // Status back to the sequencer
    // ---------------------------------------------------------------------
    assign i_req.ready = (w_uw.op == OP_LOAD);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_out_free  = !r_o_valid || o_rsp.ready;

    always_comb begin
        w_sts.in_valid  = i_req.valid;
        w_sts.bad_date  = (r_y == 14'd0) || (r_y > YEAR_MAX) || (r_m == 4'd0)
                       || (r_m > MONTH_DEC) || (r_d == 5'd0) || (r_d > w_dim);
        w_sts.walk_done = (r_left == 15'd0) || r_ovf;
        w_sts.skip_done = r_ovf || !w_off;
        w_sts.out_free  = w_out_free;
    end

    // ---------------------------------------------------------------------
    // Datapath, one micro-op per cycle
    // ---------------------------------------------------------------------
    always_comb begin
        n_d    = r_d;
        n_m    = r_m;
        n_y    = r_y;
        n_left = r_left;
        n_q100 = r_q100;
        n_c100 = r_c100;
        n_sum  = r_sum;
        n_q7   = r_q7;
        n_wd   = r_wd;
        n_bad  = r_bad;
        n_ovf  = r_ovf;
        unique case (w_uw.op)
            OP_LOAD: begin
                // latch the request; flags and weekday start cleared
                if (w_accept) begin
                    n_d    = i_req.start_day;
                    n_m    = i_req.start_month;
                    n_y    = i_req.start_year;
                    n_left = i_req.days_count;
                    n_wd   = 3'd0;
                    n_bad  = 1'b0;
                    n_ovf  = 1'b0;
                end
            end
            OP_DIV100: n_q100 = w_prod100[SHIFT_100 +: 8];
            OP_REM100: n_c100 = 7'(r_y - 14'(r_q100 * 7'd100));
            OP_SUM: begin
                // d + yy + yy/4 - yy/100 + yy/400 + floor(31*mm/12)
                n_sum = 15'(r_d) + 15'(w_yy) + 15'(w_yy[YEAR_W-1:2])
                      + 15'(w_qyy[7:2]) + 15'(month_term(r_m)) - 15'(w_qyy);
            end
            OP_QUO:  n_q7 = w_prod7[SHIFT_7 +: 13];
            OP_WDAY: n_wd = 3'(r_sum - 15'(r_q7 * 3'd7));
            OP_WALK: begin
                // spend one count on a working day, then advance or saturate
                if ((r_left != 15'd0) && !r_ovf) begin
                    if (!w_off) begin
                        n_left = r_left - 15'd1;
                    end
                    if (w_at_limit) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_d    = w_adv_d;
                        n_m    = w_adv_m;
                        n_y    = w_adv_y;
                        n_q100 = w_adv_q100;
                        n_c100 = w_adv_c100;
                        n_wd   = w_adv_wd;
                    end
                end
            end
            OP_SKIP: begin
                // pass trailing weekend days
                if (!r_ovf && w_off) begin
                    if (w_at_limit) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_d    = w_adv_d;
                        n_m    = w_adv_m;
                        n_y    = w_adv_y;
                        n_q100 = w_adv_q100;
                        n_c100 = w_adv_c100;
                        n_wd   = w_adv_wd;
                    end
                end
            end
            OP_BAD:  n_bad = 1'b1;
            OP_EMIT, OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_m    <= n_m;
        r_y    <= n_y;
        r_left <= n_left;
        r_q100 <= n_q100;
        r_c100 <= n_c100;
        r_sum  <= n_sum;
        r_q7   <= n_q7;
        r_wd   <= n_wd;
        r_bad  <= n_bad;
        r_ovf  <= n_ovf;
    end

    // ---------------------------------------------------------------------
    // Output register: load on EMIT when free, drop on handshake
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if ((w_uw.op == OP_EMIT) && w_out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((w_uw.op == OP_EMIT) && w_out_free) begin
            r_o_d   <= r_d;
            r_o_m   <= r_m;
            r_o_y   <= r_y;
            r_o_wd  <= r_wd;
            r_o_bad <= r_bad;
            r_o_ovf <= r_ovf;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.ret_day     = r_o_d;
    assign o_rsp.ret_month   = r_o_m;
    assign o_rsp.ret_year    = r_o_y;
    assign o_rsp.ret_weekday = r_o_wd;
    assign o_rsp.bad_date    = r_o_bad;
    assign o_rsp.overflow    = r_o_ovf;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    // a response is never both a bad date and a saturated walk
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_o_bad && r_o_ovf))
        else $error("bad_date and overflow both set");

    // a normal result always lands on a working day
    a_lands_on_workday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_bad && !r_o_ovf) |-> !w_mask8[r_o_wd])
        else $error("result weekday is marked as weekend");

    // the walk only ever holds valid calendar dates
    a_walk_date_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_uw.op == OP_WALK) || (w_uw.op == OP_SKIP))
            |-> (r_d != 5'd0) && (r_d <= w_dim) && (r_m != 4'd0) && (r_m <= MONTH_DEC))
        else $error("walk reached an invalid date");

    // saturation only happens on the last representable day
    a_ovf_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_ovf) && (w_uw.op != OP_LOAD))
            |-> (r_d == 5'd31) && (r_m == MONTH_DEC) && (r_y == YEAR_MAX))
        else $error("overflow raised away from 31/12/9999");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import bdda_pkg::*;

    // One request as the sender holds it: a start date and a count of working days.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [COUNT_W-1:0] count;
    } t_date_request;

    // One response: the return date, its weekday and the two flags.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [WDAY_W-1:0]  weekday;
        logic               bad_date;
        logic               overflow;
    } t_return_date;

    localparam int LAST_YEAR   = 9999;
    localparam int TOP_YEAR    = 16383;
    localparam int TOP_COUNT   = 32767;
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES  = 9;

    // Weekend masks, bit n = weekday n with Sunday as bit 0
    localparam logic [MASK_W-1:0] NONE_OFF  = 7'h00;
    localparam logic [MASK_W-1:0] ALL_OFF   = 7'h7F;
    localparam logic [MASK_W-1:0] SAT_SUN   = 7'h41;
    localparam logic [MASK_W-1:0] ONE_WORK  = 7'h7E;
    localparam logic [MASK_W-1:0] SUN_ONLY  = 7'h01;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bdda_req_if req_bus ();
    bdda_rsp_if rsp_bus ();
    bdda_cfg_if cfg_bus ();

    business_day_date_adder uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    t_date_request     pending_requests[$];  // requests not yet presented
    t_return_date      due_returns[$];       // predicted responses, oldest first
    logic [MASK_W-1:0] weekend_model = MASK_RESET;

    bit   idle_enable = 1'b1;   // draw random gaps and stalls when set
    bit   send_hold   = 1'b0;   // hold off new requests while set
    logic req_fired   = 1'b0;   // handshakes seen at the last rising edge
    logic rsp_fired   = 1'b0;
    logic cfg_fired   = 1'b0;
    int   send_wait   = 0;
    int   stall_wait  = 0;
    int   mismatch_count = 0;

    t_date_request next_request;
    t_date_request taken;
    t_return_date  got;
    t_return_date  want;

    always #2 clk = ~clk;

    // Length of a month, zero for a month number outside 1..12.
    function automatic int month_days(input int y, input int m);
        bit leap_year;
        leap_year = (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
        case (m)
            2:                      return leap_year ? 29 : 28;
            4, 6, 9, 11:            return 30;
            1, 3, 5, 7, 8, 10, 12:  return 31;
            default:                return 0;
        endcase
    endfunction

    // Predict the response to one request under the given weekend mask.
    function automatic t_return_date add_business_days(input t_date_request rq,
                                                       input logic [MASK_W-1:0] off_days);
        t_return_date r;
        int d, m, y, left, wd, shift, yy, mm;
        d    = rq.day;
        m    = rq.month;
        y    = rq.year;
        left = rq.count;
        wd   = 0;
        r    = '0;
        if (y < 1 || y > LAST_YEAR || m < 1 || m > 12 || d < 1 || d > month_days(y, m)) begin
            // echo the start date, weekday 0
            r.bad_date = 1'b1;
        end else begin
            // weekday from the shifted year that opens in March
            shift = (14 - m) / 12;
            yy    = y - shift;
            mm    = m + 12 * shift - 2;
            wd    = (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
            // spend the count on working days, then roll past trailing weekend days;
            // stop dead on the last day of year 9999
            while (!r.overflow && (left > 0 || off_days[wd])) begin
                if (left > 0 && !off_days[wd])
                    left--;
                if (d != month_days(y, m)) begin
                    d++;
                end else if (m != 12) begin
                    m++;
                    d = 1;
                end else if (y < LAST_YEAR) begin
                    y++;
                    m = 1;
                    d = 1;
                end else begin
                    r.overflow = 1'b1;
                end
                if (!r.overflow)
                    wd = (wd + 1) % 7;
            end
        end
        r.day     = DAY_W'(d);
        r.month   = MONTH_W'(m);
        r.year    = YEAR_W'(y);
        r.weekday = WDAY_W'(wd);
        return r;
    endfunction

    function automatic int draw_wait();
        return idle_enable ? $urandom_range(0, 18) : 0;
    endfunction

    task automatic report_mismatch(input string what, input t_return_date exp_r,
                                   input t_return_date act_r);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected %0d/%0d/%0d wd %0d bad %0b ovf %0b,",
                     $realtime, what,
                     exp_r.day, exp_r.month, exp_r.year, exp_r.weekday, exp_r.bad_date,
                     exp_r.overflow,
                     " got %0d/%0d/%0d wd %0d bad %0b ovf %0b",
                     act_r.day, act_r.month, act_r.year, act_r.weekday, act_r.bad_date,
                     act_r.overflow);
    endtask

    // ------------------------------------------------------------------
    // Request driver: present one request at a time on the falling edge,
    // hold it until taken, then wait out a freshly drawn gap.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : request_driver
        if (req_fired)
            send_wait = draw_wait();
        if (req_bus.valid && !req_fired) begin
            // hold the current request until the block takes it
        end else if (send_wait > 0) begin
            req_bus.valid <= 1'b0;
            send_wait--;
        end else if (pending_requests.size() > 0 && !send_hold) begin
            next_request = pending_requests.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.start_day   <= next_request.day;
            req_bus.start_month <= next_request.month;
            req_bus.start_year  <= next_request.year;
            req_bus.days_count  <= next_request.count;
        end else begin
            req_bus.valid <= 1'b0;
        end
    end

    // Response side: after each response taken, drop ready for a drawn stall.
    always @(negedge clk) begin : return_ready_driver
        if (rsp_fired)
            stall_wait = draw_wait();
        if (stall_wait > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_wait--;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample every handshake at the rising edge. A request taken
    // queues its predicted response; a response taken is checked against
    // the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : monitor
        req_fired <= rst_n && req_bus.valid && req_bus.ready;
        rsp_fired <= rst_n && rsp_bus.valid && rsp_bus.ready;
        cfg_fired <= rst_n && cfg_bus.valid && cfg_bus.ready;
        if (rst_n && cfg_bus.valid && cfg_bus.ready)
            weekend_model = cfg_bus.weekend_mask;
        if (rst_n && req_bus.valid && req_bus.ready) begin
            taken = '{req_bus.start_day, req_bus.start_month, req_bus.start_year,
                      req_bus.days_count};
            due_returns.push_back(add_business_days(taken, weekend_model));
        end
        if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.ret_day, rsp_bus.ret_month, rsp_bus.ret_year,
                    rsp_bus.ret_weekday, rsp_bus.bad_date, rsp_bus.overflow};
            if (due_returns.size() == 0) begin
                report_mismatch("response with no request pending", '0, got);
            end else begin
                want = due_returns.pop_front();
                if (got.day !== want.day || got.month !== want.month ||
                    got.year !== want.year || got.weekday !== want.weekday ||
                    got.bad_date !== want.bad_date || got.overflow !== want.overflow)
                    report_mismatch("response mismatch", want, got);
            end
        end
    end

    task automatic queue_request(input int d, input int m, input int y, input int c);
        t_date_request rq;
        rq.day   = DAY_W'(d);
        rq.month = MONTH_W'(m);
        rq.year  = YEAR_W'(y);
        rq.count = COUNT_W'(c);
        pending_requests.push_back(rq);
    endtask

    // Fill the queue with random requests shaped to the current mask.
    task automatic queue_random_requests(input int n);
        t_date_request rq;
        int y, m, md, kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 12 || weekend_model == ALL_OFF) begin
                // for kind below 12 or with every day off, keep valid starts in the last years
                y = $urandom_range(LAST_YEAR - 2, LAST_YEAR);
            end else if (kind < 30) begin
                y = $urandom_range(0, 1) ? $urandom_range(1, 8)
                                         : $urandom_range(1, LAST_YEAR);
            end else begin
                y = $urandom_range(1, LAST_YEAR);
            end
            m  = $urandom_range(1, 12);
            md = month_days(y, m);
            rq.year  = YEAR_W'(y);
            rq.month = MONTH_W'(m);
            rq.day   = DAY_W'(($urandom_range(0, 7) == 0) ? md : $urandom_range(1, md));
            if (kind < 12 || weekend_model == ALL_OFF)
                rq.count = COUNT_W'($urandom_range(0, TOP_COUNT));
            else if (kind < 15)
                rq.count = COUNT_W'($urandom_range(0, 1500));
            else if ($urandom_range(0, 9) == 0)
                rq.count = '0;
            else
                rq.count = COUNT_W'($urandom_range(0, 40));
            if (kind >= 88) begin
                // break one field of the date; the count never matters then
                rq.count = COUNT_W'($urandom_range(0, TOP_COUNT));
                case ($urandom_range(0, 3))
                    0: rq.year  = $urandom_range(0, 1) ? '0
                                : YEAR_W'($urandom_range(LAST_YEAR + 1, TOP_YEAR));
                    1: rq.month = $urandom_range(0, 1) ? '0
                                : MONTH_W'($urandom_range(13, 15));
                    2: rq.day   = '0;
                    default: rq.day = (md < 31) ? DAY_W'($urandom_range(md + 1, 31)) : '0;
                endcase
            end
            pending_requests.push_back(rq);
        end
    endtask

    // Wait until every request is sent and every response has come back.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || req_bus.valid || due_returns.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_weekend_mask(input logic [MASK_W-1:0] value);
        @(negedge clk);
        cfg_bus.valid        <= 1'b1;
        cfg_bus.weekend_mask <= value;
        @(negedge clk);
        while (!cfg_fired)
            @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed requests under the reset mask, all days off and no
    // days off, then random phases, each opening with a weekend mask write.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [MASK_W-1:0] phase_masks [6];
        logic [MASK_W-1:0] mask_value;
        phase_masks = '{NONE_OFF, ALL_OFF, MASK_RESET, SAT_SUN, ONE_WORK, SUN_ONLY};

        req_bus.valid        = 1'b0;
        req_bus.start_day    = '0;
        req_bus.start_month  = '0;
        req_bus.start_year   = '0;
        req_bus.days_count   = '0;
        rsp_bus.ready        = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.weekend_mask = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset mask: Friday and Saturday off
        queue_request(1, 1, 1, 0);           // earliest date, no count
        queue_request(1, 1, 1, 1);
        queue_request(31, 12, LAST_YEAR, 0); // last date is a Friday: overflow at once
        queue_request(31, 12, LAST_YEAR, 1);
        queue_request(30, 11, LAST_YEAR, 100);
        queue_request(28, 2, 2024, 1);       // leap year
        queue_request(28, 2, 1900, 1);       // century, not leap
        queue_request(29, 2, 2000, 3);       // every 400 years, leap
        queue_request(29, 2, 2023, 2);       // no such day
        queue_request(31, 4, 2020, 2);
        queue_request(0, 5, 2020, 2);
        queue_request(15, 0, 2020, 2);
        queue_request(15, 13, 2020, 2);
        queue_request(15, 15, 2020, 2);
        queue_request(1, 1, 0, 2);
        queue_request(1, 1, LAST_YEAR + 1, 2);
        queue_request(31, 15, TOP_YEAR, TOP_COUNT);
        queue_request(31, 12, 2020, 5);      // year rollover
        queue_request(5, 1, 2024, 0);        // a Friday with no count still rolls to Sunday
        queue_request(1, 1, 2000, TOP_COUNT);
        wait_drained();

        // Every day off: any valid start walks to the end of year 9999
        write_weekend_mask(ALL_OFF);
        queue_request(1, 1, LAST_YEAR, 0);
        queue_request(15, 6, LAST_YEAR - 1, 3);
        wait_drained();

        // No day off
        write_weekend_mask(NONE_OFF);
        queue_request(28, 2, 2100, 1);
        queue_request(31, 12, LAST_YEAR, 0);
        queue_request(30, 12, LAST_YEAR, 1);
        queue_request(30, 12, LAST_YEAR, 2);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            mask_value = (phase < 6) ? phase_masks[phase] : MASK_W'($urandom_range(0, 127));
            write_weekend_mask(mask_value);
            idle_enable = (phase % 3 != 2);
            queue_random_requests(PHASE_ITEMS);
            if (phase == 4) begin
                // hold the sender mid-phase until every response is back
                while (pending_requests.size() > PHASE_ITEMS / 2)
                    @(posedge clk);
                send_hold = 1'b1;
                while (req_bus.valid || due_returns.size() != 0)
                    @(posedge clk);
                repeat ($urandom_range(1, 30)) @(posedge clk);
                send_hold = 1'b0;
            end
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run
    initial begin : watchdog
        #60000000;
        $display("testbench failed");
        $finish;
    end

endmodule

>>> files.f
rtl/core/bdda_pkg.sv
rtl/core/bdda_req_if.sv
rtl/core/bdda_rsp_if.sv
rtl/core/bdda_cfg_if.sv
rtl/core/bdda_seq.sv
rtl/core/business_day_date_adder.sv
tb/testbench.sv
